### rtl/jtg_pkg.sv
`timescale 1ns / 1ps

package jtg_pkg;

  localparam int DEFL_W     = 16;
  localparam int POS_W      = 32;
  localparam int TICK_W     = 10;
  localparam int TGT_W      = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int SDB_W      = 15;
  localparam int FS_W       = 15;
  localparam int RATE_W     = 16;
  localparam int CDB_W      = 16;
  localparam int LEAD_W     = 31;
  localparam int SOFT_W     = 31;

  // deadbanded deflection magnitude, up to 32768
  localparam int MAG_W      = 16;

  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = 42;

  localparam int DIV_N_W    = PROD_W;
  localparam int DIV_D_W    = 15;
  localparam int DIV_DIGITS = DIV_N_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_DIGITS + 1);

  localparam int STEP_W     = 17;
  localparam int T_W        = 36;

  localparam logic [DIV_D_W-1:0] MS_PER_SECOND = 15'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STICK_DEADBAND   = 3'd0,
    CFG_STICK_FULL_SCALE = 3'd1,
    CFG_JOG_MAX_RATE     = 3'd2,
    CFG_CENTER_RATE      = 3'd3,
    CFG_CENTER_DEADBAND  = 3'd4,
    CFG_LEAD_LIMIT       = 3'd5,
    CFG_SOFT_LIMIT       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

endpackage

### rtl/jtg_if.sv
`timescale 1ns / 1ps

interface jtg_stick_if import jtg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DEFL_W-1:0] raw_deflection;
  logic signed [POS_W-1:0]  actual_position;
  logic        [TICK_W-1:0] tick_ms;

  modport source (output valid, output raw_deflection, output actual_position,
                  output tick_ms, input ready);
  modport sink   (input valid, input raw_deflection, input actual_position,
                  input tick_ms, output ready);
endinterface

interface jtg_target_if import jtg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TGT_W-1:0] new_target;

  modport source (output valid, output new_target, input ready);
  modport sink   (input valid, input new_target, output ready);
endinterface

### rtl/jtg_mul_serial.sv
`timescale 1ns / 1ps

module jtg_mul_serial import jtg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  ma;
  logic [MUL_B_W-1:0] mb;

  // shift-add, one multiplier bit a cycle, stops once no set bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      mb <= '0;
    end else if (req.start) begin
      acc <= '0;
      ma  <= PROD_W'(req.a);
      mb  <= req.b;
    end else if (mb != '0) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

  assign done    = (mb == '0);
  assign product = acc;

endmodule

### rtl/jtg_div_serial.sv
`timescale 1ns / 1ps

module jtg_div_serial import jtg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  logic [DIV_N_W-1:0]   n;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   d;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W:0]     r1;
  logic [DIV_D_W:0]     r1s;
  logic [DIV_D_W:0]     r2;
  logic [DIV_D_W:0]     r2s;
  logic                 ge1;
  logic                 ge2;

  // radix-4 restoring step: two bits of quotient a cycle, remainder stays below d
  always_comb begin
    r1  = {rem, n[DIV_N_W-1]};
    ge1 = (r1 >= {1'b0, d});
    r1s = ge1 ? r1 - {1'b0, d} : r1;
    r2  = {r1s[DIV_D_W-1:0], n[DIV_N_W-2]};
    ge2 = (r2 >= {1'b0, d});
    r2s = ge2 ? r2 - {1'b0, d} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      n   <= req.dividend;
      d   <= req.divisor;
      rem <= '0;
      cnt <= DIV_CNT_W'(DIV_DIGITS);
    end else if (cnt != '0) begin
      n   <= {n[DIV_N_W-3:0], ge1, ge2};
      rem <= r2s[DIV_D_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign done     = (cnt == '0);
  assign quotient = n;

endmodule

### rtl/jog_target_generator.sv
`timescale 1ns / 1ps
// channel  modport  payload                                       handshake
// stick    sink     raw_deflection, actual_position, tick_ms      valid/ready
// target   source   new_target                                    valid/ready
// cfg      write    cfg_index, cfg_data                           cfg_we
//
// One item at a time. A jogging item runs a shift-add multiply over
// jog_max_rate bits, a division by full scale, a multiply over tick_ms bits and
// a division by 1000. rst is synchronous and clears the kept target to zero.
// The result sits in an output register; a stalled target channel holds the
// finished item, and the next item may be taken and worked on meanwhile, but
// its result is loaded only once the finished item has been handed over.

module jog_target_generator import jtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  jtg_stick_if.sink             stick,
  jtg_target_if.source          target,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_CENTER = 8'b0001_0000,
    S_CDB    = 8'b0010_0000,
    S_LEAD   = 8'b0100_0000,
    S_SOFT   = 8'b1000_0000
  } state_t;

  localparam logic signed [T_W-1:0] T_MAX = {{(T_W-TGT_W+1){1'b0}}, {(TGT_W-1){1'b1}}};
  localparam logic signed [T_W-1:0] T_MIN = {{(T_W-TGT_W+1){1'b1}}, {(TGT_W-1){1'b0}}};

  logic [SDB_W-1:0]  stick_deadband;
  logic [FS_W-1:0]   stick_full_scale;
  logic [RATE_W-1:0] jog_max_rate;
  logic [RATE_W-1:0] center_rate;
  logic [CDB_W-1:0]  center_deadband;
  logic [LEAD_W-1:0] lead_limit;
  logic [SOFT_W-1:0] soft_limit;

  state_t state, state_next;
  logic signed [DEFL_W-1:0] raw;
  logic signed [POS_W-1:0]  pos;
  logic [TICK_W-1:0]        tick;
  logic signed [TGT_W-1:0]  last_target;
  logic signed [T_W-1:0]    t, t_next;
  logic                     jog, jog_next;
  logic                     second, second_next;
  logic                     dneg, dneg_next;
  logic                     out_valid;
  logic signed [TGT_W-1:0]  out_data;
  logic                     load_out;

  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done;
  logic               div_done;
  logic [PROD_W-1:0]  product;
  logic [DIV_N_W-1:0] quotient;

  logic signed [DEFL_W:0] raw_ext;
  logic [DEFL_W:0]        raw_abs;
  logic [DEFL_W:0]        dmag_full;
  logic [MAG_W-1:0]       dmag;
  logic                   defl_zero;

  logic signed [T_W-1:0] last_ext;
  logic signed [T_W-1:0] delta;
  logic signed [T_W-1:0] step_ext;
  logic signed [T_W-1:0] cdb_ext;
  logic signed [T_W-1:0] pos_ext;
  logic signed [T_W-1:0] lead_ext;
  logic signed [T_W-1:0] soft_ext;
  logic signed [T_W-1:0] diff;
  logic signed [T_W-1:0] t_soft;
  logic signed [T_W-1:0] t_sat;

  jtg_mul_serial u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (product)
  );

  jtg_div_serial u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_deadband   <= '0;
      stick_full_scale <= '0;
      jog_max_rate     <= '0;
      center_rate      <= '0;
      center_deadband  <= '0;
      lead_limit       <= '0;
      soft_limit       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STICK_DEADBAND:   stick_deadband   <= cfg_data[SDB_W-1:0];
        CFG_STICK_FULL_SCALE: stick_full_scale <= cfg_data[FS_W-1:0];
        CFG_JOG_MAX_RATE:     jog_max_rate     <= cfg_data[RATE_W-1:0];
        CFG_CENTER_RATE:      center_rate      <= cfg_data[RATE_W-1:0];
        CFG_CENTER_DEADBAND:  center_deadband  <= cfg_data[CDB_W-1:0];
        CFG_LEAD_LIMIT:       lead_limit       <= cfg_data[LEAD_W-1:0];
        CFG_SOFT_LIMIT:       soft_limit       <= cfg_data[SOFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign stick.ready = (state == S_IDLE);

  always_comb begin
    raw_ext   = {raw[DEFL_W-1], raw};
    raw_abs   = raw[DEFL_W-1] ? $unsigned(-raw_ext) : $unsigned(raw_ext);
    dmag_full = raw_abs - {2'b00, stick_deadband};
    dmag      = dmag_full[MAG_W-1:0];
    defl_zero = (raw_abs < {2'b00, stick_deadband}) || (dmag == '0);

    last_ext = {{(T_W-TGT_W){last_target[TGT_W-1]}}, last_target};
    delta    = $signed({{(T_W-TGT_W){1'b0}}, quotient[TGT_W-1:0]});
    step_ext = $signed({{(T_W-STEP_W){1'b0}}, quotient[STEP_W-1:0]});
    cdb_ext  = $signed({{(T_W-CDB_W){1'b0}}, center_deadband});
    pos_ext  = {{(T_W-POS_W){pos[POS_W-1]}}, pos};
    lead_ext = $signed({{(T_W-LEAD_W){1'b0}}, lead_limit});
    soft_ext = $signed({{(T_W-SOFT_W){1'b0}}, soft_limit});
    diff     = t - pos_ext;

    t_soft = t;
    if (soft_limit != '0) begin
      if (t > soft_ext) begin
        t_soft = soft_ext;
      end else if (t < -soft_ext) begin
        t_soft = -soft_ext;
      end
    end
    if (t_soft > T_MAX) begin
      t_sat = T_MAX;
    end else if (t_soft < T_MIN) begin
      t_sat = T_MIN;
    end else begin
      t_sat = t_soft;
    end
  end

  always_comb begin
    state_next  = state;
    t_next      = t;
    jog_next    = jog;
    second_next = second;
    dneg_next   = dneg;
    mul_req     = '0;
    div_req     = '0;
    load_out    = 1'b0;
    case (state)
      S_IDLE: begin
        if (stick.valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        dneg_next = raw[DEFL_W-1];
        if (!defl_zero && stick_full_scale != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(dmag);
          mul_req.b     = jog_max_rate;
          jog_next      = 1'b1;
          second_next   = 1'b0;
          state_next    = S_MUL;
        end else if (defl_zero && center_rate != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_A_W'(center_rate);
          mul_req.b     = MUL_B_W'(tick);
          jog_next      = 1'b0;
          second_next   = 1'b0;
          state_next    = S_MUL;
        end else begin
          t_next     = last_ext;
          state_next = S_LEAD;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = product;
          div_req.divisor  = (jog && !second) ? stick_full_scale : MS_PER_SECOND;
          state_next       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (jog && !second) begin
            mul_req.start = 1'b1;
            mul_req.a     = quotient[MUL_A_W-1:0];
            mul_req.b     = MUL_B_W'(tick);
            second_next   = 1'b1;
            state_next    = S_MUL;
          end else if (jog) begin
            t_next     = dneg ? last_ext - delta : last_ext + delta;
            state_next = S_LEAD;
          end else begin
            state_next = S_CENTER;
          end
        end
      end
      S_CENTER: begin
        if (last_ext > step_ext) begin
          t_next = last_ext - step_ext;
        end else if (last_ext < -step_ext) begin
          t_next = last_ext + step_ext;
        end else begin
          t_next = '0;
        end
        state_next = S_CDB;
      end
      S_CDB: begin
        if (t > -cdb_ext && t < cdb_ext) begin
          t_next = '0;
        end
        state_next = S_LEAD;
      end
      S_LEAD: begin
        if (diff > lead_ext) begin
          t_next = pos_ext + lead_ext;
        end else if (diff < -lead_ext) begin
          t_next = pos_ext - lead_ext;
        end
        state_next = S_SOFT;
      end
      S_SOFT: begin
        if (!out_valid || target.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_target <= '0;
      out_valid   <= 1'b0;
      jog         <= 1'b0;
      second      <= 1'b0;
    end else begin
      state  <= state_next;
      jog    <= jog_next;
      second <= second_next;
      if (load_out) begin
        last_target <= t_sat[TGT_W-1:0];
        out_valid   <= 1'b1;
      end else if (target.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t    <= t_next;
    dneg <= dneg_next;
    if (stick.valid && stick.ready) begin
      raw  <= stick.raw_deflection;
      pos  <= stick.actual_position;
      tick <= stick.tick_ms;
    end
    if (load_out) begin
      out_data <= t_sat[TGT_W-1:0];
    end
  end

  assign target.valid      = out_valid;
  assign target.new_target = out_data;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> div_req.divisor != '0)
    else $error("divider started with zero divisor");

  a_kept_target: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (target.valid && last_target == target.new_target))
    else $error("kept target differs from emitted item");

  a_soft_bound: assert property (@(posedge clk) disable iff (rst)
    (load_out && soft_limit != '0) |=>
      ($signed(target.new_target) <= $signed({1'b0, soft_limit}) &&
       $signed(target.new_target) >= -$signed({1'b0, soft_limit})))
    else $error("emitted target outside soft limit");

endmodule

### dv/tb_jog_target_generator.sv
`timescale 1ns / 1ps

module tb_jog_target_generator import jtg_pkg::*; ();

  localparam longint MS_IN_S = 1000;
  localparam longint TGT_MAX = 2147483647;
  localparam longint TGT_MIN = -TGT_MAX - 1;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 200;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    cfg_reg_t                 sel;
    logic [CFG_DATA_W-1:0]    value;
    logic signed [DEFL_W-1:0] defl;
    logic signed [POS_W-1:0]  pos;
    logic [TICK_W-1:0]        tick;
    bit                       known;
    logic signed [TGT_W-1:0]  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  jtg_stick_if  stick_if ();
  jtg_target_if target_if ();

  jog_target_generator dut (
    .clk       (clk),
    .rst       (rst),
    .stick     (stick_if),
    .target    (target_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register shadow and kept target
  longint dz_band    = 0;
  longint full_scale = 0;
  longint max_rate   = 0;
  longint ctr_rate   = 0;
  longint ctr_band   = 0;
  longint lead_lim   = 0;
  longint soft_lim   = 0;
  longint track_target = 0;

  logic signed [TGT_W-1:0] target_q [$];
  stim_row_t               plan [$];

  int n_items, n_checked, n_errs, n_writes;
  int n_jog, n_ctr, n_hold, n_lead, n_soft, n_sat;
  int burst_left;

  int       rx_mode;
  int       rx_left;
  logic [7:0] rx_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint clip32(longint v);
    if (v > TGT_MAX) return TGT_MAX;
    if (v < TGT_MIN) return TGT_MIN;
    return v;
  endfunction

  function automatic longint next_target(longint raw, longint pos, longint tk);
    longint defl, spd, stp, t;
    spd = 0;
    if (raw > -dz_band && raw < dz_band) defl = 0;
    else if (raw > 0) defl = raw - dz_band;
    else defl = raw + dz_band;
    if (defl != 0) begin
      if (full_scale != 0) spd = (defl * max_rate) / full_scale;
      t = track_target + (spd * tk) / MS_IN_S;
      n_jog++;
    end else if (ctr_rate > 0) begin
      stp = (ctr_rate * tk) / MS_IN_S;
      if (track_target > stp) t = track_target - stp;
      else if (track_target < -stp) t = track_target + stp;
      else t = 0;
      if (t > -ctr_band && t < ctr_band) t = 0;
      n_ctr++;
    end else begin
      t = track_target;
      n_hold++;
    end
    if (t - pos > lead_lim) begin
      t = pos + lead_lim;
      n_lead++;
    end
    if (t - pos < -lead_lim) begin
      t = pos - lead_lim;
      n_lead++;
    end
    if (soft_lim > 0) begin
      if (t > soft_lim) begin
        t = soft_lim;
        n_soft++;
      end
      if (t < -soft_lim) begin
        t = -soft_lim;
        n_soft++;
      end
    end
    if (t > TGT_MAX || t < TGT_MIN) n_sat++;
    return clip32(t);
  endfunction

  function automatic void add_item(longint d, longint p, longint tk, bit known = 0,
                                   longint want = 0);
    stim_row_t row;
    row.kind  = ROW_ITEM;
    row.sel   = CFG_STICK_DEADBAND;
    row.value = '0;
    row.defl  = DEFL_W'(d);
    row.pos   = POS_W'(p);
    row.tick  = TICK_W'(tk);
    row.known = known;
    row.want  = TGT_W'(want);
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, longint v);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.sel   = sel;
    row.value = CFG_DATA_W'(v);
    row.defl  = '0;
    row.pos   = '0;
    row.tick  = '0;
    row.known = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  task automatic settle();
    stick_if.valid <= 1'b0;
    while (target_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, longint v);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= CFG_DATA_W'(v);
    @(posedge clk);
    case (sel)
      CFG_STICK_DEADBAND:   dz_band    = v;
      CFG_STICK_FULL_SCALE: full_scale = v;
      CFG_JOG_MAX_RATE:     max_rate   = v;
      CFG_CENTER_RATE:      ctr_rate   = v;
      CFG_CENTER_DEADBAND:  ctr_band   = v;
      CFG_LEAD_LIMIT:       lead_lim   = v;
      CFG_SOFT_LIMIT:       soft_lim   = v;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_item(logic signed [DEFL_W-1:0] d, logic signed [POS_W-1:0] p,
                           logic [TICK_W-1:0] tk, bit known, logic signed [TGT_W-1:0] want);
    longint t;
    cfg_we                   <= 1'b0;
    stick_if.valid           <= 1'b1;
    stick_if.raw_deflection  <= d;
    stick_if.actual_position <= p;
    stick_if.tick_ms         <= tk;
    @(posedge clk);
    while (!stick_if.ready) @(posedge clk);
    t = next_target(d, p, tk);
    track_target = t;
    if (known) begin
      target_q.push_back(want);
    end else begin
      target_q.push_back(TGT_W'(t));
    end
    n_items++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 100);
      if (gap > 0) begin
        stick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // result side: own stall pattern, compare against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      target_if.ready <= 1'b0;
      rx_mode <= 0;
      rx_left <= 0;
      rx_cnt  <= '0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(64, 256);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_cnt <= rx_cnt + 1'b1;
      case (rx_mode)
        0:       target_if.ready <= 1'b1;
        1:       target_if.ready <= ($urandom_range(0, 3) != 0);
        2:       target_if.ready <= ($urandom_range(0, 3) == 0);
        default: target_if.ready <= (rx_cnt[3:0] < 4'd5);
      endcase
      if (target_if.valid && target_if.ready) begin
        if (target_q.size() == 0) begin
          $error("new_target %0d arrived with none expected", target_if.new_target);
          n_errs++;
        end else begin
          if (target_if.new_target !== target_q[0]) begin
            $error("new_target mismatch: expected %0d, actual %0d",
                   target_q[0], target_if.new_target);
            n_errs++;
          end
          void'(target_q.pop_front());
          n_checked++;
        end
      end
    end
  end

  initial begin
    longint d, p, off;
    longint v_sdb, v_fs, v_rate, v_cr, v_cdb, v_lead, v_soft;
    logic signed [15:0] r16;
    logic signed [31:0] r32;
    int tk;

    rst                      <= 1'b1;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_STICK_DEADBAND;
    cfg_data                 <= '0;
    stick_if.valid           <= 1'b0;
    stick_if.raw_deflection  <= '0;
    stick_if.actual_position <= '0;
    stick_if.tick_ms         <= '0;
    burst_left = 1;

    // all registers zero: target follows position
    add_item(0, 0, 0, 1, 0);
    add_item(32767, TGT_MAX, 1000, 1, TGT_MAX);
    add_item(-32768, TGT_MIN, 1023, 1, TGT_MIN);
    add_item(1, -5, 1, 1, -5);
    add_cfg(CFG_LEAD_LIMIT, TGT_MAX);
    add_cfg(CFG_STICK_DEADBAND, 100);
    add_cfg(CFG_STICK_FULL_SCALE, 1000);
    add_cfg(CFG_JOG_MAX_RATE, 1000);
    add_item(50, 0, 1000);
    add_item(-100, 0, 1000);
    add_item(1100, 0, 1000);
    add_item(-1100, 0, 500);
    add_item(10123, 0, 3);
    add_item(-2017, 0, 7);
    add_cfg(CFG_STICK_FULL_SCALE, 0);
    add_item(32767, 0, 1000);
    add_cfg(CFG_STICK_FULL_SCALE, 1000);
    add_cfg(CFG_CENTER_RATE, 1000);
    add_cfg(CFG_CENTER_DEADBAND, 300);
    add_item(5100, 0, 1000);
    add_item(0, 0, 1023);
    add_item(0, 0, 1000);
    add_item(0, 0, 1000);
    add_cfg(CFG_LEAD_LIMIT, 10);
    add_cfg(CFG_SOFT_LIMIT, 2000);
    add_item(32767, 0, 1000, 1, 10);
    add_item(-32768, 0, 1000, 1, -10);
    add_cfg(CFG_LEAD_LIMIT, TGT_MAX);
    add_item(32767, 0, 1000, 1, 2000);
    add_item(-32768, 0, 1000, 1, -2000);
    // saturation of the kept target at both ends
    add_cfg(CFG_SOFT_LIMIT, 0);
    add_cfg(CFG_STICK_FULL_SCALE, 1);
    add_cfg(CFG_JOG_MAX_RATE, 65535);
    add_cfg(CFG_STICK_DEADBAND, 0);
    add_cfg(CFG_CENTER_RATE, 0);
    add_item(32767, TGT_MAX, 1023, 1, TGT_MAX);
    add_item(-32768, TGT_MIN, 1023);
    add_item(-32768, TGT_MIN, 1023, 1, TGT_MIN);
    add_cfg(CFG_CENTER_RATE, 65535);
    add_cfg(CFG_CENTER_DEADBAND, 65535);
    add_item(0, 0, 1023);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_item(plan[i].defl, plan[i].pos, plan[i].tick, plan[i].known, plan[i].want);
        pace();
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == 0) begin
        v_sdb = 32767; v_fs = 32767; v_rate = 65535; v_cr = 65535;
        v_cdb = 65535; v_lead = TGT_MAX; v_soft = TGT_MAX;
      end else if (ph == 1) begin
        v_sdb = 0; v_fs = 0; v_rate = 0; v_cr = 0; v_cdb = 0; v_lead = 0; v_soft = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       v_sdb = 0;
          1:       v_sdb = $urandom_range(0, 32767);
          default: v_sdb = $urandom_range(0, 2000);
        endcase
        v_fs   = (ph == 2) ? 0 : $urandom_range(1, 32767);
        v_rate = $urandom_range(0, 65535);
        v_cr   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 65535);
        v_cdb  = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 500);
        case ($urandom_range(0, 3))
          0:       v_lead = $urandom_range(0, 1000);
          1:       v_lead = $urandom_range(0, 1 << 20);
          2:       v_lead = $urandom_range(0, TGT_MAX);
          default: v_lead = TGT_MAX;
        endcase
        case ($urandom_range(0, 3))
          0, 1:    v_soft = 0;
          2:       v_soft = $urandom_range(1, 1 << 20);
          default: v_soft = $urandom_range(1, TGT_MAX);
        endcase
      end
      write_reg(CFG_STICK_DEADBAND, v_sdb);
      write_reg(CFG_STICK_FULL_SCALE, v_fs);
      write_reg(CFG_JOG_MAX_RATE, v_rate);
      write_reg(CFG_CENTER_RATE, v_cr);
      write_reg(CFG_CENTER_DEADBAND, v_cdb);
      write_reg(CFG_LEAD_LIMIT, v_lead);
      write_reg(CFG_SOFT_LIMIT, v_soft);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 7))
          0, 1: begin
            r16 = 16'($urandom);
            d = r16;
          end
          2: d = 0;
          3: begin
            d = $urandom_range(0, dz_band);
            if ($urandom_range(0, 1)) d = -d;
          end
          default: begin
            d = dz_band + longint'($urandom_range(1, full_scale + 1));
            if ($urandom_range(0, 1)) d = -d;
          end
        endcase
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;

        // mostly a position that follows the target, as a real axis would
        case ($urandom_range(0, 9))
          0: begin
            r32 = $urandom;
            p = r32;
          end
          1: p = $urandom_range(0, 1) ? TGT_MAX : TGT_MIN;
          2, 3: p = track_target + ($urandom_range(0, 1) ? lead_lim : -lead_lim)
                    + longint'($urandom_range(0, 6)) - 3;
          default: begin
            off = $urandom_range(0, 1 << $urandom_range(0, 30));
            p = track_target + ($urandom_range(0, 1) ? off : -off);
          end
        endcase
        p = clip32(p);

        case ($urandom_range(0, 7))
          0:       tk = 1000;
          1:       tk = $urandom_range(0, 20);
          default: tk = $urandom_range(0, 1023);
        endcase

        send_item(DEFL_W'(d), POS_W'(p), TICK_W'(tk), 1'b0, '0);
        pace();
      end
    end

    settle();
    repeat (100) @(posedge clk);

    $display("%0d items sent, %0d targets checked, %0d register writes",
             n_items, n_checked, n_writes);
    $display("jog %0d, centring %0d, hold %0d; lead clamps %0d, soft clamps %0d, saturated %0d",
             n_jog, n_ctr, n_hold, n_lead, n_soft, n_sat);
    if (n_errs == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
